/* hw/rtl/kkol_pkg.sv */
// Shared types, constants and MD5 round tables for the ketama key owner lookup unit.
// No dependencies; every other file except kkol_ram imports it.
package kkol_pkg;

  localparam int TableDepth  = 4096;
  localparam int AddrW       = $clog2(TableDepth);
  localparam int CountW      = AddrW + 1;
  localparam int ServerBits  = 8;
  localparam int CfgCountW   = 13;
  localparam int CfgW        = 13;
  localparam int SlotW       = 12;
  localparam int FifoDepth   = 2;

  localparam logic       CMD_WRITE = 1'b0;
  localparam logic       CMD_KEY   = 1'b1;

  localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
  localparam logic [1:0] REG_OWN_INDEX   = 2'd1;
  localparam logic [1:0] REG_TABLE_VALID = 2'd2;

  localparam logic [31:0] MD5_IV0 = 32'h67452301;
  localparam logic [31:0] MD5_IV1 = 32'hefcdab89;
  localparam logic [31:0] MD5_IV2 = 32'h98badcfe;
  localparam logic [31:0] MD5_IV3 = 32'h10325476;

  typedef enum logic [1:0] {
    ITEM_WRITE    = 2'd0,
    ITEM_KEY      = 2'd1,
    ITEM_KEY_LAST = 2'd2
  } item_kind_e;

  typedef struct packed {
    item_kind_e      kind;
    logic [SlotW-1:0] slot;
    logic [31:0]     point;
    logic [7:0]      owner;
    logic [7:0]      key_byte;
  } item_t;

  typedef struct packed {
    logic [CfgCountW-1:0] entry_count;
    logic [7:0]           own_index;
    logic                 table_valid;
  } cfg_t;

  typedef struct packed {
    logic ready;
    logic finishing;
  } md5_stat_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;  6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee;  6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;  6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;  6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821;  6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;  6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453;  6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;  6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed;  6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;  6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681;  6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;  6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70;  6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;  6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5;  6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;  6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039;  6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;  6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0;  6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;  6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [3:0] i);
    logic [4:0] s;
    case (i)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/ketama_key_owner_lookup_unit.sv */
// Top level of the ketama key owner lookup unit: configuration registers, front and back end.
// Depends on kkol_pkg, kkol_front and kkol_back.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------------
//  item in  | start & !busy             | command, entry_slot/point/owner, key_byte, last_byte
//  result   | result_valid_o (1 cycle)  | owner_index_o, self_index_o, is_mine_o
//  config   | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// A table write or a plain key byte retires as it leaves the two-entry queue; every 64th
// key byte starts a compression (one MD5 round per cycle, then a chain add). A last byte
// adds one or two finishing compressions, then a binary search of up to ceil(log2(n+1))
// steps (one table RAM read each) and a final owner read when the table is valid.
// busy goes high while the queue is full. Reset clears control state only; table entries
// are undefined until written, and there is no clearing pass. Results cannot be stalled.
module ketama_key_owner_lookup_unit import kkol_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             command_i,
  input  logic [SlotW-1:0] entry_slot_i,
  input  logic [31:0]      entry_point_i,
  input  logic [7:0]       entry_owner_i,
  input  logic [7:0]       key_byte_i,
  input  logic             last_byte_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  output logic             result_valid_o,
  output logic [7:0]       owner_index_o,
  output logic [7:0]       self_index_o,
  output logic             is_mine_o
);

  cfg_t  cfg_q, cfg_d;
  item_t head;
  logic  head_valid, pop, full;

  assign busy = full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENTRY_COUNT: cfg_d.entry_count = cfg_wdata_i[CfgCountW-1:0];
        REG_OWN_INDEX:   cfg_d.own_index   = cfg_wdata_i[7:0];
        REG_TABLE_VALID: cfg_d.table_valid = cfg_wdata_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  kkol_front u_front (
    .clk_i,
    .rst_ni,
    .push_i        (start && !full),
    .command_i,
    .entry_slot_i,
    .entry_point_i,
    .entry_owner_i,
    .key_byte_i,
    .last_byte_i,
    .full_o        (full),
    .head_valid_o  (head_valid),
    .head_o        (head),
    .pop_i         (pop)
  );

  kkol_back u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .cfg_i          (cfg_q),
    .result_valid_o,
    .owner_index_o,
    .self_index_o,
    .is_mine_o
  );

endmodule

/* hw/rtl/kkol_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kkol_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/kkol_front.sv */
// Front end: classifies incoming transactions and queues them for the back end.
// Depends on kkol_pkg.
module kkol_front import kkol_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             command_i,
  input  logic [SlotW-1:0] entry_slot_i,
  input  logic [31:0]      entry_point_i,
  input  logic [7:0]       entry_owner_i,
  input  logic [7:0]       key_byte_i,
  input  logic             last_byte_i,
  output logic             full_o,
  output logic             head_valid_o,
  output item_t            head_o,
  input  logic             pop_i
);

  localparam int PtrW = $clog2(FifoDepth);

  item_t           fifo_q [FifoDepth];
  item_t           item;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  always_comb begin
    item.slot     = entry_slot_i;
    item.point    = entry_point_i;
    item.owner    = entry_owner_i;
    item.key_byte = key_byte_i;
    if (command_i == CMD_WRITE) begin
      item.kind = ITEM_WRITE;
    end else if (last_byte_i) begin
      item.kind = ITEM_KEY_LAST;
    end else begin
      item.kind = ITEM_KEY;
    end
  end

  assign full_o       = (cnt_q == (PtrW+1)'(FifoDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

endmodule

/* hw/rtl/kkol_md5.sv */
// MD5 engine: byte buffer, length counter, one round per cycle, padding and finish.
// Depends on kkol_pkg.
module kkol_md5 import kkol_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_valid_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output md5_stat_t   stat_o,
  output logic        done_o,
  output logic [31:0] key_point_o
);

  typedef enum logic [2:0] {
    M_IDLE  = 3'b001,
    M_ROUND = 3'b010,
    M_ADD   = 3'b100
  } md5_state_e;

  typedef enum logic [1:0] {
    BLK_RAW  = 2'd0,
    BLK_PAD1 = 2'd1,
    BLK_PAD2 = 2'd2
  } blk_kind_e;

  md5_state_e  st_q, st_d;
  blk_kind_e   blk_q, blk_d;
  logic        fin_q, fin_d;
  logic [63:0] len_q, len_d, new_len, bit_len;
  logic [5:0]  idx0_q, idx0_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [31:0] buf_q [16];
  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] sum [4];
  logic [31:0] a_q, b_q, c_q, d_q, a_d, b_d, c_d, d_d;
  logic [31:0] f, t, w, raw_w, rot;
  logic [3:0]  g, ix;
  logic [4:0]  s;
  logic        accept, len_in_blk;
  logic [5:0]  pos;

  assign accept  = byte_valid_i && (st_q == M_IDLE);
  assign new_len = len_q + 64'd1;
  assign bit_len = {len_q[60:0], 3'b000};
  assign len_in_blk = (blk_q == BLK_PAD2) || ((blk_q == BLK_PAD1) && (idx0_q < 6'd56));

  assign stat_o.ready     = (st_q == M_IDLE);
  assign stat_o.finishing = fin_q;

  for (genvar i = 0; i < 4; i++) begin : g_sum
    assign sum[i] = chain_q[i] + ((i == 0) ? a_q : (i == 1) ? b_q : (i == 2) ? c_q : d_q);
  end

  // Round function, message schedule and padded word fetch
  always_comb begin
    ix = rnd_q[3:0];
    unique case (rnd_q[5:4])
      2'd0: begin
        f = (b_q & c_q) | (~b_q & d_q);
        g = ix;
      end
      2'd1: begin
        f = (d_q & b_q) | (~d_q & c_q);
        g = 4'(ix * 4'd5 + 4'd1);
      end
      2'd2: begin
        f = b_q ^ c_q ^ d_q;
        g = 4'(ix * 4'd3 + 4'd5);
      end
      default: begin
        f = c_q ^ (b_q | ~d_q);
        g = 4'(ix * 4'd7);
      end
    endcase
    s = md5_rot({rnd_q[5:4], rnd_q[1:0]});

    raw_w = buf_q[g];
    w     = '0;
    pos   = '0;
    for (int k = 0; k < 4; k++) begin
      pos = {g, 2'(k)};
      case (blk_q)
        BLK_RAW: w[8*k +: 8] = raw_w[8*k +: 8];
        BLK_PAD1: begin
          if (pos < idx0_q) begin
            w[8*k +: 8] = raw_w[8*k +: 8];
          end else if (pos == idx0_q) begin
            w[8*k +: 8] = 8'h80;
          end
        end
        default: w[8*k +: 8] = 8'h00;
      endcase
    end
    if (len_in_blk && (g == 4'd14)) begin
      w = bit_len[31:0];
    end else if (len_in_blk && (g == 4'd15)) begin
      w = bit_len[63:32];
    end

    t   = a_q + f + md5_k(rnd_q) + w;
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
  end

  always_comb begin
    st_d    = st_q;
    blk_d   = blk_q;
    fin_d   = fin_q;
    len_d   = len_q;
    idx0_d  = idx0_q;
    rnd_d   = rnd_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    chain_d = chain_q;
    done_o  = 1'b0;
    key_point_o = sum[0];
    unique case (st_q)
      M_IDLE: begin
        if (accept) begin
          len_d = new_len;
          a_d = chain_q[0];
          b_d = chain_q[1];
          c_d = chain_q[2];
          d_d = chain_q[3];
          rnd_d = '0;
          if (new_len[5:0] == 6'd0) begin
            st_d  = M_ROUND;
            blk_d = BLK_RAW;
            fin_d = last_i;
          end else if (last_i) begin
            st_d   = M_ROUND;
            blk_d  = BLK_PAD1;
            fin_d  = 1'b1;
            idx0_d = new_len[5:0];
          end
        end
      end
      M_ROUND: begin
        a_d   = d_q;
        d_d   = c_q;
        c_d   = b_q;
        b_d   = b_q + rot;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == 6'd63) begin
          st_d = M_ADD;
        end
      end
      M_ADD: begin
        chain_d = sum;
        a_d = sum[0];
        b_d = sum[1];
        c_d = sum[2];
        d_d = sum[3];
        rnd_d = '0;
        if (!fin_q) begin
          st_d = M_IDLE;
        end else if (blk_q == BLK_RAW) begin
          // block filled exactly on the last byte: padding starts a fresh block
          st_d   = M_ROUND;
          blk_d  = BLK_PAD1;
          idx0_d = '0;
        end else if ((blk_q == BLK_PAD1) && !len_in_blk) begin
          st_d  = M_ROUND;
          blk_d = BLK_PAD2;
        end else begin
          done_o     = 1'b1;
          st_d       = M_IDLE;
          fin_d      = 1'b0;
          len_d      = '0;
          chain_d[0] = MD5_IV0;
          chain_d[1] = MD5_IV1;
          chain_d[2] = MD5_IV2;
          chain_d[3] = MD5_IV3;
        end
      end
      default: st_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= M_IDLE;
      blk_q      <= BLK_RAW;
      fin_q      <= 1'b0;
      len_q      <= '0;
      idx0_q     <= '0;
      rnd_q      <= '0;
      chain_q[0] <= MD5_IV0;
      chain_q[1] <= MD5_IV1;
      chain_q[2] <= MD5_IV2;
      chain_q[3] <= MD5_IV3;
    end else begin
      st_q    <= st_d;
      blk_q   <= blk_d;
      fin_q   <= fin_d;
      len_q   <= len_d;
      idx0_q  <= idx0_d;
      rnd_q   <= rnd_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
    if (accept) begin
      buf_q[len_q[5:2]][8*len_q[1:0] +: 8] <= byte_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> fin_q && (st_q == M_ADD))
    else $error("digest finished outside a final block");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == M_ROUND) && (rnd_q == 6'd63) |=> (st_q == M_ADD))
    else $error("compression did not end after the last round");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (len_q == 64'd0) && !fin_q)
    else $error("hash state not restarted after a key");

endmodule

/* hw/rtl/kkol_back.sv */
// Back end: applies table writes, drives the MD5 engine and runs the ring binary search.
// Depends on kkol_pkg, kkol_ram and kkol_md5.
module kkol_back import kkol_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  item_t       head_i,
  output logic        pop_o,
  input  cfg_t        cfg_i,
  output logic        result_valid_o,
  output logic [7:0]  owner_index_o,
  output logic [7:0]  self_index_o,
  output logic        is_mine_o
);

  typedef enum logic [3:0] {
    B_IDLE   = 4'b0001,
    B_SEARCH = 4'b0010,
    B_WAIT   = 4'b0100,
    B_OWN    = 4'b1000
  } back_state_e;

  back_state_e          st_q, st_d;
  md5_stat_t            md5_stat;
  logic                 md5_done, md5_byte_valid, is_write;
  logic [31:0]          key_point, key_q, key_d;
  logic [CountW-1:0]    lo_q, lo_d, hi_q, hi_d, n_q, n_d, mid_q, mid_d, mid, n_clamp;
  logic [AddrW-1:0]     raddr;
  logic                 tbl_we;
  logic [31:0]          point_rd;
  logic [ServerBits-1:0] owner_rd;
  logic                 res_valid_q, res_valid_d, mine_q, mine_d;
  logic [7:0]           owner_q, owner_d, self_q, self_d;

  assign is_write = (head_i.kind == ITEM_WRITE);
  // a write waits while a key is finishing so the search sees the table as of the last byte
  assign pop_o = head_valid_i && (st_q == B_IDLE) &&
                 (is_write ? !md5_stat.finishing : md5_stat.ready);
  assign tbl_we = pop_o && is_write && (32'(head_i.slot) < 32'(TableDepth));
  assign md5_byte_valid = pop_o && !is_write;

  assign n_clamp = (32'(cfg_i.entry_count) > 32'(TableDepth)) ? CountW'(TableDepth)
                                                               : CountW'(cfg_i.entry_count);
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  kkol_md5 u_md5 (
    .clk_i,
    .rst_ni,
    .byte_valid_i (md5_byte_valid),
    .byte_i       (head_i.key_byte),
    .last_i       (head_i.kind == ITEM_KEY_LAST),
    .stat_o       (md5_stat),
    .done_o       (md5_done),
    .key_point_o  (key_point)
  );

  kkol_ram #(.Width(32), .Depth(TableDepth)) u_point_ram (
    .clk_i,
    .we_i    (tbl_we),
    .waddr_i (AddrW'(head_i.slot)),
    .wdata_i (head_i.point),
    .raddr_i (raddr),
    .rdata_o (point_rd)
  );

  kkol_ram #(.Width(ServerBits), .Depth(TableDepth)) u_owner_ram (
    .clk_i,
    .we_i    (tbl_we),
    .waddr_i (AddrW'(head_i.slot)),
    .wdata_i (head_i.owner[ServerBits-1:0]),
    .raddr_i (raddr),
    .rdata_o (owner_rd)
  );

  always_comb begin
    st_d        = st_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    n_d         = n_q;
    mid_d       = mid_q;
    raddr       = '0;
    res_valid_d = 1'b0;
    owner_d     = owner_q;
    self_d      = self_q;
    mine_d      = mine_q;
    unique case (st_q)
      B_IDLE: begin
        if (md5_done) begin
          if (!cfg_i.table_valid) begin
            res_valid_d = 1'b1;
            owner_d     = '0;
            self_d      = cfg_i.own_index;
            mine_d      = 1'b1;
          end else begin
            key_d = key_point;
            lo_d  = '0;
            hi_d  = n_clamp;
            n_d   = n_clamp;
            st_d  = B_SEARCH;
          end
        end
      end
      B_SEARCH: begin
        if (lo_q < hi_q) begin
          raddr = mid[AddrW-1:0];
          mid_d = mid;
          st_d  = B_WAIT;
        end else begin
          // past the last entry the ring wraps to the first one
          raddr = (lo_q >= n_q) ? '0 : lo_q[AddrW-1:0];
          st_d  = B_OWN;
        end
      end
      B_WAIT: begin
        if (point_rd < key_q) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        st_d = B_SEARCH;
      end
      B_OWN: begin
        res_valid_d = 1'b1;
        owner_d     = 8'(owner_rd);
        self_d      = cfg_i.own_index;
        mine_d      = (8'(owner_rd) == cfg_i.own_index);
        st_d        = B_IDLE;
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    n_q     <= n_d;
    mid_q   <= mid_d;
    owner_q <= owner_d;
    self_q  <= self_d;
    mine_q  <= mine_d;
  end

  assign result_valid_o = res_valid_q;
  assign owner_index_o  = owner_q;
  assign self_index_o   = self_q;
  assign is_mine_o      = mine_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("two results in consecutive cycles");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    md5_done |-> (st_q == B_IDLE))
    else $error("key finished while a search is running");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> !md5_stat.finishing && (st_q == B_IDLE))
    else $error("table written during a pending lookup");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != B_IDLE) |-> !pop_o)
    else $error("queue popped during a search");

endmodule

/* test/ketama_key_owner_lookup_unit_tb.sv */
// Self-checking testbench for the ketama key owner lookup unit.
// Needs kkol_pkg and the unit's RTL; an in-bench MD5 and ring search predict each owner.
module ketama_key_owner_lookup_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kkol_pkg::*;

  localparam int  CycleLimit = 3000000;
  localparam int  SettleCycles = 400;
  localparam int  LargeRing = 128;
  localparam int  KeyItemsPerRing = 45;

  typedef struct {
    logic [7:0] owner;
    logic [7:0] self_idx;
    logic       mine;
  } lookup_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             command_i = CMD_WRITE;
  logic [SlotW-1:0] entry_slot_i = '0;
  logic [31:0]      entry_point_i = '0;
  logic [7:0]       entry_owner_i = '0;
  logic [7:0]       key_byte_i = '0;
  logic             last_byte_i = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_idx_i = REG_ENTRY_COUNT;
  logic [CfgW-1:0]  cfg_wdata_i = '0;
  logic             result_valid_o;
  logic [7:0]       owner_index_o;
  logic [7:0]       self_index_o;
  logic             is_mine_o;

  ketama_key_owner_lookup_unit uut (.*);

  always #4 clk_i = ~clk_i;

  // ring and hash mirror
  logic [31:0]  ring_point [TableDepth];
  logic [7:0]   ring_owner [TableDepth];
  logic [31:0]  chain [4];
  logic [511:0] key_block;
  logic [63:0]  key_len;
  logic [12:0]  entry_count;
  logic [7:0]   own_index;
  logic         table_valid;

  lookup_t owner_q[$];
  int      mismatches = 0;
  int      lookups_seen = 0;
  int      items_sent = 0;
  int      cycles = 0;
  int      burst_left = 0;
  bit      no_idle = 1'b0;

  logic [31:0] md5_kt [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  int md5_shift [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  function automatic void chain_restart();
    chain[0] = MD5_IV0;
    chain[1] = MD5_IV1;
    chain[2] = MD5_IV2;
    chain[3] = MD5_IV3;
  endfunction

  function automatic void md5_block(input logic [511:0] blk);
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int g, s;
    for (int i = 0; i < 16; i++) w[i] = blk[32*i +: 32];
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * i) % 16;
      end
      s = md5_shift[(i / 16) * 4 + (i % 4)];
      t = a + f + md5_kt[i] + w[g];
      a = d; d = c; c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endfunction

  function automatic logic [31:0] key_point_finish();
    logic [511:0] blk;
    int idx;
    blk = key_block;
    idx = int'(key_len[5:0]);
    blk[8*idx +: 8] = 8'h80;
    idx++;
    if (idx > 56) begin
      for (int j = idx; j < 64; j++) blk[8*j +: 8] = 8'h00;
      md5_block(blk);
      idx = 0;
    end
    for (int j = idx; j < 56; j++) blk[8*j +: 8] = 8'h00;
    blk[511:448] = key_len << 3;
    md5_block(blk);
    return chain[0];
  endfunction

  // Advance the mirror by one accepted transaction; queue the owner it yields.
  function automatic void predict_owner(input logic cmd, input logic [SlotW-1:0] slot,
                                        input logic [31:0] pt, input logic [7:0] own,
                                        input logic [7:0] kb, input logic last);
    logic [31:0] kp;
    int n, lo, hi, mid;
    lookup_t r;
    if (cmd == CMD_WRITE) begin
      ring_point[slot] = pt;
      ring_owner[slot] = own;
      return;
    end
    key_block[8*int'(key_len[5:0]) +: 8] = kb;
    key_len++;
    if (!last) begin
      if (key_len[5:0] == 6'd0) md5_block(key_block);
      return;
    end
    if (key_len[5:0] == 6'd0) begin
      md5_block(key_block);
      key_block = '0;
    end
    kp = key_point_finish();
    chain_restart();
    key_len = '0;
    r.self_idx = own_index;
    if (!table_valid) begin
      r.owner = 8'h00;
      r.mine = 1'b1;
    end else begin
      n = (entry_count > TableDepth) ? TableDepth : int'(entry_count);
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (ring_point[mid] < kp) lo = mid + 1;
        else hi = mid;
      end
      if (lo >= n) lo = 0;
      r.owner = ring_owner[lo];
      r.mine = (r.owner == own_index);
    end
    owner_q.push_back(r);
  endfunction

  // Caller stands at a rising edge; returns at the accepting edge or after a burst's idle gap.
  task automatic send_item(input logic cmd, input logic [SlotW-1:0] slot,
                           input logic [31:0] pt, input logic [7:0] own,
                           input logic [7:0] kb, input logic last);
    int gap;
    start <= 1'b1;
    command_i <= cmd;
    entry_slot_i <= slot;
    entry_point_i <= pt;
    entry_owner_i <= own;
    key_byte_i <= kb;
    last_byte_i <= last;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
    predict_owner(cmd, slot, pt, own, kb, last);
    items_sent++;
    if (!no_idle) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 7);
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_entry(input int slot, input logic [31:0] pt, input logic [7:0] own);
    send_item(CMD_WRITE, slot[SlotW-1:0], pt, own, 8'($urandom), 1'($urandom));
  endtask

  // Stream one key; rewrite owners of loaded slots in between now and then.
  task automatic send_key(input int len, input int loaded);
    int s;
    for (int i = 0; i < len; i++) begin
      if (loaded > 0 && $urandom_range(0, 15) == 0) begin
        s = $urandom_range(0, loaded - 1);
        send_entry(s, ring_point[s], 8'($urandom));
      end
      send_item(CMD_KEY, SlotW'($urandom), $urandom, 8'($urandom), 8'($urandom),
                i == len - 1);
    end
  endtask

  function automatic int pick_key_len();
    int edges [12] = '{1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128, 129};
    if ($urandom_range(0, 9) < 3) return edges[$urandom_range(0, 11)];
    return $urandom_range(1, 12);
  endfunction

  // Wait out all lookups, then write the three registers back to back.
  task automatic set_config(input logic [12:0] cnt, input logic [7:0] own, input logic vld);
    start <= 1'b0;
    while (owner_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_ENTRY_COUNT;
    cfg_wdata_i <= cnt;
    @(posedge clk_i);
    cfg_idx_i <= REG_OWN_INDEX;
    cfg_wdata_i <= CfgW'(own);
    @(posedge clk_i);
    cfg_idx_i <= REG_TABLE_VALID;
    cfg_wdata_i <= CfgW'(vld);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    entry_count = cnt;
    own_index = own;
    table_valid = vld;
    @(posedge clk_i);
  endtask

  // Load slots 0..n-1 with ascending points spread over the ring, in random order.
  task automatic load_ring(input int n, input int owners);
    int order [$];
    int k, tmp;
    logic [31:0] span, pt;
    for (int i = 0; i < n; i++) order.push_back(i);
    for (int i = n - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[k]; order[k] = tmp;
    end
    span = 32'hffffffff / n;
    foreach (order[i]) begin
      pt = order[i] * span + $urandom_range(0, span - 1);
      if (order[i] == 0 && $urandom_range(0, 1)) pt = 32'h0;
      if (order[i] == n - 1 && $urandom_range(0, 1)) pt = 32'hffffffff;
      send_entry(order[i], pt, 8'($urandom_range(0, owners - 1)));
    end
  endtask

  task automatic test_directed();
    // invalid table: owner 0, mine, own index echoed
    send_key(1, 0);
    set_config(13'd5, 8'hff, 1'b0);
    send_item(CMD_KEY, '1, '1, '1, 8'hff, 1'b1);
    send_item(CMD_KEY, '0, '0, '0, 8'h00, 1'b1);
    send_entry(0, 32'h0, 8'h00);
    send_entry(1, 32'h80000000, 8'hff);
    send_entry(2, 32'hffffffff, 8'h07);
    // empty ring while valid wraps to entry 0
    set_config(13'd0, 8'h00, 1'b1);
    send_key(2, 0);
    set_config(13'd3, 8'hff, 1'b1);
    repeat (6) send_key(1, 3);
    set_config(13'd3, 8'h07, 1'b1);
    send_key(3, 3);
  endtask

  task automatic test_random_rings();
    int n, owners, target;
    for (int ph = 0; ph < 10; ph++) begin
      no_idle = (ph % 4 == 3);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
      owners = $urandom_range(1, 3) == 1 ? 256 : $urandom_range(1, 6);
      load_ring(n, owners);
      case (ph % 5)
        0: set_config(13'(n), 8'h00, 1'b1);
        1: set_config(13'(n), 8'hff, 1'b1);
        2: set_config(13'(n), 8'h00, 1'b0);
        default: set_config(13'(n), 8'($urandom_range(0, owners - 1)), 1'b1);
      endcase
      target = items_sent + KeyItemsPerRing;
      while (items_sent < target) send_key(pick_key_len(), n);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_large_ring();
    load_ring(LargeRing, 256);
    set_config(13'(LargeRing), 8'hff, 1'b1);
    repeat (6) send_key(pick_key_len(), LargeRing);
    // an invalid table ignores the count, even one beyond the depth
    set_config(13'h1fff, 8'h80, 1'b0);
    repeat (2) send_key(pick_key_len(), LargeRing);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      lookups_seen++;
      if (owner_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected lookup result owner=%0d", owner_index_o);
      end else begin
        lookup_t e;
        e = owner_q.pop_front();
        if (owner_index_o !== e.owner || self_index_o !== e.self_idx ||
            is_mine_o !== e.mine) begin
          mismatches++;
          if (mismatches <= 10)
            $display("lookup mismatch: exp owner=%0d self=%0d mine=%0d, got %0d %0d %0d",
                     e.owner, e.self_idx, e.mine, owner_index_o, self_index_o, is_mine_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    chain_restart();
    key_block = '0;
    key_len = '0;
    entry_count = '0;
    own_index = '0;
    table_valid = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_rings();
    test_large_ring();
    start <= 1'b0;
    while (owner_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d transactions and %0d lookups over invalid, empty, small and large rings",
             items_sent, lookups_seen);
    $display("mismatches: %0d, lookups left over: %0d", mismatches, owner_q.size());
    if (mismatches == 0 && owner_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
